// ----- sv/ksr_pkg.sv -----
package ksr_pkg;

   localparam int IDX_EXT_W  = 17;
   localparam int ACC_W      = 48;
   localparam int MAG_W      = 47;
   localparam int VAL_W      = 32;
   localparam int VARS_W     = 11;
   localparam int THRESH_W   = 31;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_VARS_IN_USE    = 1'b0;
   localparam logic CSR_ZERO_THRESHOLD = 1'b1;

   localparam logic [VARS_W-1:0] VARS_RESET = 11'd1024;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_CLEAR      = 3'd0,
      OP_SET_DUAL   = 3'd1,
      OP_JACOBIAN   = 3'd2,
      OP_ADD        = 3'd3,
      OP_READ       = 3'd4,
      OP_MAX_REPORT = 3'd5
   } ksr_op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_FETCH,
      ST_ACC,
      ST_SCAN
   } ksr_state_type;

   typedef struct packed {
      logic load;
      logic use_product;
   } ksr_upd_ctrl_type;

   // |v| clamped to 47 bits; the most negative value maps to the max
   function automatic logic [MAG_W-1:0] mag47(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-1:0] n;
      begin
         n = v[ACC_W-1] ? (~v + 48'd1) : v;
         return n[ACC_W-1] ? {MAG_W{1'b1}} : n[MAG_W-1:0];
      end
   endfunction

endpackage

// ----- sv/kkt_stationarity_residual_top.sv -----
// From accept to result strobe: set dual and unused opcodes strobe in the next cycle, read
// after the accumulator read, add and jacobian entry after the dual and accumulator read,
// product register and write back, max report after it reads n entries, one read a cycle,
// n = min(vars_in_use, MAX_VARIABLES). Clear sweeps both stores one entry a cycle.
// One item at a time; the next item is taken in the cycle its predecessor's result shows.
// Reset runs the same sweep with busy high; results are never held.
module kkt_stationarity_residual_top #(
   parameter int MAX_CONSTRAINTS = 1024,
   parameter int MAX_VARIABLES   = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic [9:0]         req_row_index,
   input  logic [9:0]         req_col_index,
   input  logic signed [31:0] req_entry_value,
   output logic               rsp_valid,
   output logic signed [47:0] rsp_residual_value,
   output logic               rsp_residual_nonzero,
   output logic [46:0]        rsp_max_abs_residual,
   output logic               rsp_saturated,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import ksr_pkg::*;

   localparam int RowAw = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
   localparam int VarAw = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
   localparam int VarCw = $clog2(MAX_VARIABLES + 1);
   localparam int ClrN  = (MAX_CONSTRAINTS > MAX_VARIABLES) ? MAX_CONSTRAINTS
                                                            : MAX_VARIABLES;
   localparam int ClrAw = (ClrN > 1) ? $clog2(ClrN) : 1;

   logic signed [VAL_W-1:0] dual_mem [MAX_CONSTRAINTS];
   logic signed [ACC_W-1:0] acc_mem  [MAX_VARIABLES];

   ksr_state_type state_ff, state_in;
   ksr_op_type    op_ff, op_in, op_cur;

   logic [VARS_W-1:0]       vars_ff;
   logic [THRESH_W-1:0]     thresh_ff;
   logic                    sat_ff, sat_in;
   logic [ClrAw-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [VarCw-1:0]        scan_cnt_ff, scan_cnt_in;
   logic [VarCw-1:0]        scan_n_ff, scan_n_in;
   logic                    scan_vld_ff, scan_vld_in;
   logic [MAG_W-1:0]        max_ff, max_in;
   logic                    dual_ok_ff, dual_ok_in;
   logic                    col_ok_ff, col_ok_in;
   logic [VarAw-1:0]        col_addr_ff, col_addr_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic signed [VAL_W-1:0] dual_rd_ff;
   logic signed [ACC_W-1:0] acc_rd_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_nz_ff, rsp_nz_in;
   logic [MAG_W-1:0]        rsp_max_ff, rsp_max_in;
   logic                    rsp_sat_ff;

   logic                    dual_we, dual_re;
   logic [RowAw-1:0]        dual_waddr, dual_raddr;
   logic signed [VAL_W-1:0] dual_wdata;
   logic                    acc_we, acc_re;
   logic [VarAw-1:0]        acc_waddr, acc_raddr;
   logic signed [ACC_W-1:0] acc_wdata;

   logic [IDX_EXT_W-1:0]    row_ext, col_ext, clr_ext, vars_ext, n_ext;
   logic                    row_ok, col_ok, clr_last, scan_done, accept, csr_write;
   logic [MAG_W-1:0]        acc_mag;
   logic signed [VAL_W-1:0] dual_eff;
   ksr_upd_ctrl_type        upd_ctrl;
   logic signed [ACC_W-1:0] upd_sum;
   logic                    upd_clamp;

   assign op_cur    = ksr_op_type'(req_opcode);
   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign row_ext   = IDX_EXT_W'(req_row_index);
   assign col_ext   = IDX_EXT_W'(req_col_index);
   assign clr_ext   = IDX_EXT_W'(clr_cnt_ff);
   assign vars_ext  = IDX_EXT_W'(vars_ff);
   assign n_ext     = (vars_ext < IDX_EXT_W'(MAX_VARIABLES)) ? vars_ext
                                                             : IDX_EXT_W'(MAX_VARIABLES);
   assign row_ok    = row_ext < IDX_EXT_W'(MAX_CONSTRAINTS);
   assign col_ok    = col_ext < IDX_EXT_W'(MAX_VARIABLES);
   assign clr_last  = clr_cnt_ff == ClrAw'(ClrN - 1);
   assign scan_done = (scan_cnt_ff == scan_n_ff) && !scan_vld_ff;
   assign acc_mag   = mag47(acc_rd_ff);
   assign dual_eff  = dual_ok_ff ? dual_rd_ff : '0;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_ZERO_THRESHOLD)
                      ? {{(CSR_DATA_W-THRESH_W){1'b0}}, thresh_ff}
                      : {{(CSR_DATA_W-VARS_W){1'b0}}, vars_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vars_ff   <= VARS_RESET;
         thresh_ff <= '0;
      end else if (csr_write) begin
         if (paddr[2] == CSR_VARS_IN_USE) begin
            vars_ff <= pwdata[VARS_W-1:0];
         end else begin
            thresh_ff <= pwdata[THRESH_W-1:0];
         end
      end
   end

   ksr_update u_update (
      .clock (clock),
      .ctrl  (upd_ctrl),
      .dual  (dual_eff),
      .value (value_ff),
      .acc   (acc_rd_ff),
      .sum   (upd_sum),
      .clamp (upd_clamp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_INIT, ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (op_cur) inside
                  OP_CLEAR:                       state_in = ST_CLEAR;
                  OP_JACOBIAN, OP_ADD, OP_READ:   state_in = ST_FETCH;
                  OP_MAX_REPORT:                  state_in = ST_SCAN;
                  default:                        state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH: state_in = (op_ff == OP_READ) ? ST_IDLE : ST_ACC;
         ST_ACC:   state_in = ST_IDLE;
         ST_SCAN: begin
            if (scan_done) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      op_in        = op_ff;
      sat_in       = sat_ff;
      clr_cnt_in   = clr_cnt_ff;
      scan_cnt_in  = scan_cnt_ff;
      scan_n_in    = scan_n_ff;
      scan_vld_in  = 1'b0;
      max_in       = max_ff;
      dual_ok_in   = dual_ok_ff;
      col_ok_in    = col_ok_ff;
      col_addr_in  = col_addr_ff;
      value_in     = value_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = '0;
      rsp_nz_in    = 1'b0;
      rsp_max_in   = '0;
      dual_we      = 1'b0;
      dual_re      = 1'b0;
      dual_waddr   = row_ext[RowAw-1:0];
      dual_raddr   = row_ext[RowAw-1:0];
      dual_wdata   = req_entry_value;
      acc_we       = 1'b0;
      acc_re       = 1'b0;
      acc_waddr    = col_addr_ff;
      acc_raddr    = col_ext[VarAw-1:0];
      acc_wdata    = upd_sum;
      upd_ctrl     = '0;

      unique case (state_ff) inside
         ST_INIT, ST_CLEAR: begin
            dual_we    = clr_ext < IDX_EXT_W'(MAX_CONSTRAINTS);
            dual_waddr = clr_ext[RowAw-1:0];
            dual_wdata = '0;
            acc_we     = clr_ext < IDX_EXT_W'(MAX_VARIABLES);
            acc_waddr  = clr_ext[VarAw-1:0];
            acc_wdata  = '0;
            clr_cnt_in = clr_last ? '0 : clr_cnt_ff + 1'b1;
            if (state_ff == ST_CLEAR && clr_last) rsp_valid_in = 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               op_in       = op_cur;
               dual_ok_in  = row_ok;
               col_ok_in   = col_ok;
               col_addr_in = col_ext[VarAw-1:0];
               value_in    = req_entry_value;
               dual_re     = 1'b1;
               acc_re      = 1'b1;
               unique case (op_cur) inside
                  OP_CLEAR: begin
                     sat_in     = 1'b0;
                     clr_cnt_in = '0;
                  end
                  OP_SET_DUAL: begin
                     dual_we      = row_ok;
                     rsp_valid_in = 1'b1;
                  end
                  OP_JACOBIAN, OP_ADD, OP_READ: begin
                  end
                  OP_MAX_REPORT: begin
                     scan_cnt_in = '0;
                     scan_n_in   = n_ext[VarCw-1:0];
                     max_in      = '0;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_FETCH: begin
            if (op_ff == OP_READ) begin
               rsp_valid_in = 1'b1;
               if (col_ok_ff) begin
                  rsp_value_in = acc_rd_ff;
                  rsp_nz_in    = acc_mag > {{(MAG_W-THRESH_W){1'b0}}, thresh_ff};
               end
            end else begin
               upd_ctrl.load        = 1'b1;
               upd_ctrl.use_product = op_ff == OP_JACOBIAN;
            end
         end
         ST_ACC: begin
            acc_we       = col_ok_ff;
            rsp_valid_in = 1'b1;
            if (col_ok_ff && upd_clamp) sat_in = 1'b1;
         end
         ST_SCAN: begin
            acc_raddr = scan_cnt_ff[VarAw-1:0];
            if (scan_cnt_ff != scan_n_ff) begin
               acc_re      = 1'b1;
               scan_vld_in = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
            if (scan_vld_ff && acc_mag > max_ff) max_in = acc_mag;
            if (scan_done) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = max_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dual_we) dual_mem[dual_waddr] <= dual_wdata;
      if (dual_re) dual_rd_ff <= dual_mem[dual_raddr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
      if (acc_re) acc_rd_ff <= acc_mem[acc_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sat_ff       <= 1'b0;
         clr_cnt_ff   <= '0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_value_ff <= '0;
         rsp_nz_ff    <= 1'b0;
         rsp_max_ff   <= '0;
         rsp_sat_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sat_ff       <= sat_in;
         clr_cnt_ff   <= clr_cnt_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_value_ff <= rsp_value_in;
         rsp_nz_ff    <= rsp_nz_in;
         rsp_max_ff   <= rsp_max_in;
         rsp_sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      scan_cnt_ff <= scan_cnt_in;
      scan_n_ff   <= scan_n_in;
      max_ff      <= max_in;
      dual_ok_ff  <= dual_ok_in;
      col_ok_ff   <= col_ok_in;
      col_addr_ff <= col_addr_in;
      value_ff    <= value_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_residual_value   = rsp_value_ff;
   assign rsp_residual_nonzero = rsp_nz_ff;
   assign rsp_max_abs_residual = rsp_max_ff;
   assign rsp_saturated        = rsp_sat_ff;

   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !rsp_valid)
      else $error("result beat during reset sweep");

   a_clear_drops_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_last) |=> (rsp_valid && !rsp_saturated))
      else $error("clear result missing or saturated still set");

   a_nz_implies_value: assert property (@(posedge clock) disable iff (reset)
      rsp_residual_nonzero |-> (rsp_valid && rsp_residual_value != '0))
      else $error("nonzero flag with zero residual");

   a_max_only_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_max_abs_residual != '0) |-> (rsp_valid && rsp_residual_value == '0))
      else $error("max field set outside a max report");

endmodule

// ----- sv/ksr_update.sv -----
module ksr_update (
   input  logic                             clock,
   input  ksr_pkg::ksr_upd_ctrl_type        ctrl,
   input  logic signed [31:0]               dual,
   input  logic signed [31:0]               value,
   input  logic signed [47:0]               acc,
   output logic signed [47:0]               sum,
   output logic                             clamp
);
   import ksr_pkg::*;

   logic signed [63:0]      prod;
   logic signed [ACC_W-1:0] delta_ff;
   logic signed [ACC_W-1:0] delta_in;
   logic signed [ACC_W:0]   wide_sum;

   assign prod = dual * value;

   // floor of the Q32.32 product back to Q32.16
   assign delta_in = ctrl.use_product ? prod[63:16]
                                      : {{(ACC_W-VAL_W){value[VAL_W-1]}}, value};

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         delta_ff <= delta_in;
      end
   end

   assign wide_sum = {acc[ACC_W-1], acc} + {delta_ff[ACC_W-1], delta_ff};
   assign clamp    = wide_sum[ACC_W] != wide_sum[ACC_W-1];
   assign sum      = !clamp ? wide_sum[ACC_W-1:0]
                            : (wide_sum[ACC_W] ? ACC_MIN : ACC_MAX);

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   import ksr_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int DUAL_DEPTH     = 1024;
   localparam int ACC_DEPTH      = 1024;
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int TAIL_CYCLES    = 40;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [ACC_W-1:0] value;
      logic             nonzero;
      logic [MAG_W-1:0] max_abs;
      logic             sat;
   } residual_beat_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_opcode;
   logic [9:0]         req_row_index;
   logic [9:0]         req_col_index;
   logic signed [31:0] req_entry_value;
   logic               rsp_valid;
   logic signed [47:0] rsp_residual_value;
   logic               rsp_residual_nonzero;
   logic [46:0]        rsp_max_abs_residual;
   logic               rsp_saturated;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   kkt_stationarity_residual_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (req_opcode),
      .req_row_index        (req_row_index),
      .req_col_index        (req_col_index),
      .req_entry_value      (req_entry_value),
      .rsp_valid            (rsp_valid),
      .rsp_residual_value   (rsp_residual_value),
      .rsp_residual_nonzero (rsp_residual_nonzero),
      .rsp_max_abs_residual (rsp_max_abs_residual),
      .rsp_saturated        (rsp_saturated),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow of the block's state and registers
   logic signed [VAL_W-1:0] dual_shadow [DUAL_DEPTH];
   logic signed [ACC_W-1:0] acc_shadow [ACC_DEPTH];
   logic                    sat_shadow;
   logic [VARS_W-1:0]       vars_shadow;
   logic [THRESH_W-1:0]     thresh_shadow;

   residual_beat_type pending_residuals [$];
   residual_beat_type rsp_want;
   int             mismatches;
   int             idle_cycles;
   int             burst_left;

   function automatic logic [MAG_W-1:0] abs_clamped(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W:0] w;
      w = v;
      if (w < 0) w = -w;
      if (w > $signed({2'b00, {MAG_W{1'b1}}})) return {MAG_W{1'b1}};
      return w[MAG_W-1:0];
   endfunction

   function automatic void accumulate_col(input logic [9:0] col,
                                          input logic signed [ACC_W-1:0] delta);
      logic signed [ACC_W:0] s;
      s = acc_shadow[col] + delta;
      if (s > ACC_MAX) begin
         s = ACC_MAX;
         sat_shadow = 1'b1;
      end
      if (s < ACC_MIN) begin
         s = ACC_MIN;
         sat_shadow = 1'b1;
      end
      acc_shadow[col] = s[ACC_W-1:0];
   endfunction

   function automatic residual_beat_type predict_residual(input logic [2:0] op,
                                                          input logic [9:0] row,
                                                          input logic [9:0] col,
                                                          input logic signed [31:0] val);
      residual_beat_type  beat;
      logic signed [63:0] prod;
      logic signed [ACC_W-1:0] delta;
      int unsigned        scan_n;
      logic [MAG_W-1:0]   m;
      beat = '0;
      case (op)
         OP_CLEAR: begin
            for (int i = 0; i < DUAL_DEPTH; i++) dual_shadow[i] = '0;
            for (int i = 0; i < ACC_DEPTH; i++) acc_shadow[i] = '0;
            sat_shadow = 1'b0;
         end
         OP_SET_DUAL: dual_shadow[row] = val;
         OP_JACOBIAN: begin
            prod = dual_shadow[row] * val;
            delta = prod >>> 16;
            accumulate_col(col, delta);
         end
         OP_ADD: begin
            delta = val;
            accumulate_col(col, delta);
         end
         OP_READ: begin
            beat.value = acc_shadow[col];
            beat.nonzero = (abs_clamped(acc_shadow[col]) > thresh_shadow) ||
                           (acc_shadow[col] == ACC_MIN);
         end
         OP_MAX_REPORT: begin
            scan_n = (vars_shadow > ACC_DEPTH) ? ACC_DEPTH : vars_shadow;
            for (int j = 0; j < scan_n; j++) begin
               m = abs_clamped(acc_shadow[j]);
               if (m > beat.max_abs) beat.max_abs = m;
            end
         end
         default: ;
      endcase
      beat.sat = sat_shadow;
      return beat;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_residuals.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result beat: value %0d", rsp_residual_value);
         end else begin
            rsp_want = pending_residuals.pop_front();
            if (rsp_residual_value !== rsp_want.value ||
                rsp_residual_nonzero !== rsp_want.nonzero ||
                rsp_max_abs_residual !== rsp_want.max_abs ||
                rsp_saturated !== rsp_want.sat) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("result mismatch: value %0d/%0d nonzero %0b/%0b max %0d/%0d sat %0b/%0b",
                           $signed(rsp_want.value), rsp_residual_value,
                           rsp_want.nonzero, rsp_residual_nonzero,
                           rsp_want.max_abs, rsp_max_abs_residual,
                           rsp_want.sat, rsp_saturated);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [9:0] row,
                            input logic [9:0] col, input logic signed [31:0] val);
      start <= 1'b1;
      req_opcode <= op;
      req_row_index <= row;
      req_col_index <= col;
      req_entry_value <= val;
      do @(posedge clock); while (busy !== 1'b0);
      pending_residuals.push_back(predict_residual(op, row, col, val));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_residuals.size() != 0) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic read_csr(input logic reg_sel, input logic [31:0] want);
      logic [31:0] got;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {reg_sel, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("register %0d readback: expected %0h got %0h", reg_sel, want, got);
      end
   endtask

   task automatic write_csr(input logic reg_sel, input logic [31:0] data);
      wait_for_results();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (reg_sel == CSR_VARS_IN_USE) vars_shadow = data[VARS_W-1:0];
      else thresh_shadow = data[THRESH_W-1:0];
      read_csr(reg_sel, (reg_sel == CSR_VARS_IN_USE) ? {21'd0, vars_shadow}
                                                     : {1'b0, thresh_shadow});
   endtask

   function automatic logic [9:0] pick_index();
      int unsigned sel;
      logic [31:0] r;
      sel = $urandom_range(0, 99);
      r = $urandom;
      if (sel < 75) return {6'd0, r[3:0]};
      if (sel < 90) return r[9:0];
      return r[0] ? 10'd1023 : 10'd0;
   endfunction

   function automatic logic signed [31:0] pick_value();
      int unsigned sel;
      logic [31:0] r;
      sel = $urandom_range(0, 99);
      r = $urandom;
      if (sel < 40) return {{14{r[17]}}, r[17:0]};
      if (sel < 55) return {{8{r[23]}}, r[23:0]};
      if (sel < 80) return r;
      case (r[2:0])
         3'd0: return 32'h8000_0000;
         3'd1: return 32'h7FFF_FFFF;
         3'd2: return 32'h0000_0000;
         3'd3: return 32'hFFFF_FFFF;
         default: return 32'h0001_0000;
      endcase
   endfunction

   task automatic check_reset_state();
      read_csr(CSR_VARS_IN_USE, {21'd0, VARS_RESET});
      read_csr(CSR_ZERO_THRESHOLD, 32'd0);
      send_item(OP_READ, 10'd0, 10'd0, 32'sd0);
      send_item(OP_MAX_REPORT, 10'd0, 10'd0, 32'sd0);
   endtask

   task automatic check_directed_ops();
      send_item(OP_SET_DUAL, 10'd0, 10'd0, 32'h8000_0000);
      send_item(OP_SET_DUAL, 10'd1023, 10'd0, 32'h7FFF_FFFF);
      // drive column 1023 into the negative rail
      repeat (3) send_item(OP_JACOBIAN, 10'd0, 10'd1023, 32'h7FFF_FFFF);
      send_item(OP_READ, 10'd0, 10'd1023, 32'sd0);
      send_item(OP_MAX_REPORT, 10'd0, 10'd0, 32'sd0);
      // and column 0 into the positive rail
      repeat (3) send_item(OP_JACOBIAN, 10'd1023, 10'd0, 32'h7FFF_FFFF);
      send_item(OP_READ, 10'd0, 10'd0, 32'sd0);
      // floor rounding of a tiny negative product
      send_item(OP_SET_DUAL, 10'd2, 10'd0, 32'hFFFF_FFFF);
      send_item(OP_JACOBIAN, 10'd2, 10'd7, 32'sd1);
      send_item(OP_READ, 10'd0, 10'd7, 32'sd0);
      send_item(OP_ADD, 10'd0, 10'd5, 32'hFFFF_FFFF);
      send_item(OP_READ, 10'd0, 10'd5, 32'sd0);
      send_item(OP_ADD, 10'd0, 10'd6, 32'sd0);
      send_item(OP_READ, 10'd0, 10'd6, 32'sd0);
      send_item(OP_SPARE_LO, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
      send_item(OP_SPARE_HI, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
      // dual never written reads as zero
      send_item(OP_JACOBIAN, 10'd500, 10'd9, 32'h7FFF_FFFF);
      send_item(OP_READ, 10'd0, 10'd9, 32'sd0);
      send_item(OP_CLEAR, 10'd0, 10'd0, 32'sd0);
      send_item(OP_READ, 10'd0, 10'd1023, 32'sd0);
      send_item(OP_MAX_REPORT, 10'd0, 10'd0, 32'sd0);
   endtask

   task automatic check_config_extremes();
      write_csr(CSR_VARS_IN_USE, 32'd0);
      send_item(OP_ADD, 10'd0, 10'd0, 32'sd12345);
      send_item(OP_MAX_REPORT, 10'd0, 10'd0, 32'sd0);
      write_csr(CSR_VARS_IN_USE, 32'hFFFF_FFFF);
      send_item(OP_ADD, 10'd0, 10'd1023, 32'h8000_0000);
      send_item(OP_MAX_REPORT, 10'd0, 10'd0, 32'sd0);
      write_csr(CSR_VARS_IN_USE, 32'd1);
      send_item(OP_MAX_REPORT, 10'd0, 10'd0, 32'sd0);
      write_csr(CSR_ZERO_THRESHOLD, 32'hFFFF_FFFF);
      send_item(OP_ADD, 10'd0, 10'd8, 32'h7FFF_FFFF);
      send_item(OP_READ, 10'd0, 10'd8, 32'sd0);
      send_item(OP_ADD, 10'd0, 10'd8, 32'sd1);
      send_item(OP_READ, 10'd0, 10'd8, 32'sd0);
      write_csr(CSR_ZERO_THRESHOLD, 32'd0);
      send_item(OP_READ, 10'd0, 10'd8, 32'sd0);
   endtask

   task automatic run_random_phase(input logic [VARS_W-1:0] vars,
                                   input logic [THRESH_W-1:0] thresh,
                                   input int unsigned n_items);
      int unsigned pick;
      logic [2:0]  op;
      logic [31:0] junk;
      junk = $urandom;
      write_csr(CSR_VARS_IN_USE, {junk[31:VARS_W], vars});
      junk = $urandom;
      write_csr(CSR_ZERO_THRESHOLD, {junk[31], thresh});
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(0, 999);
         if (pick < 12) op = OP_CLEAR;
         else if (pick < 220) op = OP_SET_DUAL;
         else if (pick < 580) op = OP_JACOBIAN;
         else if (pick < 740) op = OP_ADD;
         else if (pick < 940) op = OP_READ;
         else if (pick < 980) op = OP_MAX_REPORT;
         else op = pick[0] ? OP_SPARE_LO : OP_SPARE_HI;
         send_item(op, pick_index(), pick_index(), pick_value());
      end
   endtask

   task automatic check_random_traffic();
      logic [31:0] r;
      run_random_phase(11'd1024, 31'd0, 235);
      run_random_phase(11'd1, {THRESH_W{1'b1}}, 235);
      r = $urandom;
      run_random_phase(11'd0, r[30:0], 235);
      r = $urandom;
      run_random_phase(11'd2047, {7'd0, r[23:0]}, 235);
      r = $urandom;
      run_random_phase(11'($urandom_range(1, 64)), {11'd0, r[19:0]}, 235);
      run_random_phase(11'd16, 31'd0, 235);
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_opcode <= OP_CLEAR;
      req_row_index <= '0;
      req_col_index <= '0;
      req_entry_value <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      mismatches = 0;
      burst_left = 0;
      for (int i = 0; i < DUAL_DEPTH; i++) dual_shadow[i] = '0;
      for (int i = 0; i < ACC_DEPTH; i++) acc_shadow[i] = '0;
      sat_shadow = 1'b0;
      vars_shadow = VARS_RESET;
      thresh_shadow = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);

      check_reset_state();
      check_directed_ops();
      check_config_extremes();
      check_random_traffic();

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
